>>> hdl/afs_pkg.sv
// Shared types and constants of the animation frame sequencer.
package afs_pkg;

  // Largest number of frames the sequence supports
  localparam int unsigned MAX_FRAMES = 256;
  // Highest usable frame index: the cap on frame_count, minus one
  localparam int unsigned LAST_CAP   = ((MAX_FRAMES < 256) ? MAX_FRAMES : 256) - 1;

  localparam logic [15:0] PASS_SAT = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_BACK    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_LOOP   = 2'd0,
    MODE_ONCE   = 2'd1,
    MODE_BOUNCE = 2'd2,
    MODE_LOOP_N = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_FRAME_COUNT   = 2'd0,
    REG_PLAYBACK_MODE = 2'd1,
    REG_MAX_LOOPS     = 2'd2,
    REG_START_FORWARD = 2'd3
  } cfg_reg_t;

  // Outcome of one frame step
  typedef struct packed {
    logic [7:0]  frame;
    logic [15:0] pass;
    logic        dir;
    logic        valid;
  } adv_t;

endpackage

>>> hdl/animation_frame_sequencer.sv
// Top level of the animation frame sequencer: command register, step logic, result register.
//
// Animation frame sequencer. Each request carries a command (start, advance, back) and a
// start frame; each request yields exactly one result with the current, previous and
// lookahead frame indexes, their shown bits, the direction, finished and running. The
// block takes one request per clock cycle while in_stall is low. A request is held in
// the command register, the step logic then updates the sequencer state and loads the result
// register, so each result is registered and waits there while out_stall is high.
// The command register doubles as a skid stage: one more request is taken while a finished
// result waits on out_stall, so in_stall rises only during reset or when both the result
// register and the command register are full.
// Configuration (frame_count, playback_mode, max_loops, start_forward) is written through
// the cfg port, which is ready whenever the block is out of reset; write it only while no
// request is in flight. Requests are refused during reset. The frame_count is capped at
// the package limit, and zero acts as one.
module animation_frame_sequencer import afs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_start_frame,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_index,
  output logic        out_frame_shown,
  output logic [7:0]  out_prev_index,
  output logic        out_prev_shown,
  output logic [7:0]  out_lookahead_index,
  output logic        out_lookahead_shown,
  output logic        out_going_forward,
  output logic        out_finished,
  output logic        out_is_running,
  // configuration write port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // One step of the sequence from frame c, in the given mode.
  function automatic adv_t step_frame(input logic [7:0] c, input logic [15:0] pass,
                                      input logic dir, input logic [7:0] last,
                                      input mode_t mode, input logic [7:0] origin,
                                      input logic [15:0] loops);
    adv_t       r;
    logic [7:0] wrap;
    logic       inc_at_origin;
    r.frame = c;
    r.pass  = pass;
    r.dir   = dir;
    r.valid = 1'b1;
    // wrap-around target at an end
    if (dir) begin
      wrap = (c != 8'd0) ? 8'd0 : ((last != 8'd0) ? 8'd1 : 8'd0);
    end else begin
      wrap = (c == 8'd0) ? last : c - 8'd1;
    end
    inc_at_origin = (c == origin) && (pass != PASS_SAT);
    if (c != 8'd0 && c < last) begin
      r.frame = dir ? c + 8'd1 : c - 8'd1;
    end else begin
      unique case (mode)
        MODE_LOOP: begin
          if (inc_at_origin) r.pass = pass + 16'd1;
          r.frame = wrap;
        end
        MODE_ONCE: begin
          if (c != origin) r.valid = 1'b0;
          else r.frame = wrap;
        end
        MODE_BOUNCE: begin
          if (pass != PASS_SAT) r.pass = pass + 16'd1;
          if (r.pass != 16'd1) r.dir = ~dir;
          if (r.dir) begin
            if (c < last) begin
              r.frame = c + 8'd1;
            end else begin
              r.dir   = 1'b0;
              r.frame = (last != 8'd0) ? last - 8'd1 : 8'd0;
            end
          end else begin
            if (c != 8'd0) begin
              r.frame = c - 8'd1;
            end else begin
              r.dir   = 1'b1;
              r.frame = (last != 8'd0) ? 8'd1 : 8'd0;
            end
          end
        end
        MODE_LOOP_N: begin
          if (inc_at_origin) r.pass = pass + 16'd1;
          if (r.pass >= loops) r.valid = 1'b0;
          else r.frame = wrap;
        end
        default: r.valid = 1'b0;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [8:0]  frame_count_r;
  mode_t       playback_mode_r;
  logic [15:0] max_loops_r;
  logic        start_forward_r;

  // Refuse writes while reset is applied
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r   <= 9'd256;
      playback_mode_r <= MODE_LOOP;
      max_loops_r     <= 16'd0;
      start_forward_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_COUNT:   frame_count_r   <= cfg_data[8:0];
        REG_PLAYBACK_MODE: playback_mode_r <= mode_t'(cfg_data[1:0]);
        REG_MAX_LOOPS:     max_loops_r     <= cfg_data;
        REG_START_FORWARD: start_forward_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Last usable frame index: zero count acts as one, large counts are capped
  logic [7:0] last_idx;
  always_comb begin
    if (frame_count_r == 9'd0) begin
      last_idx = 8'd0;
    end else if ({23'd0, frame_count_r} > LAST_CAP + 1) begin
      last_idx = LAST_CAP[7:0];
    end else begin
      last_idx = 8'(frame_count_r - 9'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Command register (also the skid stage)
  // ---------------------------------------------------------------------------
  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_cmd_r;
  logic [7:0] s1_frame_r;
  logic       out_valid_r, out_valid_nxt;
  logic       commit;
  logic       in_take;

  // Move the held command into the result register when that register frees up
  assign commit   = s1_valid_r && (!out_valid_r || !out_stall);
  // Hold off requests during reset and while the command register cannot drain
  assign in_stall = !rst_n || (s1_valid_r && !commit);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (commit) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= in_command;
      s1_frame_r <= in_start_frame;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [7:0]  cur_frame_r, cur_frame_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  logic [7:0]  last_frame_r, last_frame_nxt;
  logic        last_valid_r, last_valid_nxt;
  logic [7:0]  origin_r, origin_nxt;
  logic [15:0] pass_r, pass_nxt;
  logic        dir_r, dir_nxt;
  logic        run_r, run_nxt;
  adv_t        adv_now;
  adv_t        adv_look;

  // Step taken by an advance from the present state
  assign adv_now = step_frame(cur_frame_r, pass_r, dir_r, last_idx, playback_mode_r,
                              origin_r, max_loops_r);

  always_comb begin
    cur_frame_nxt  = cur_frame_r;
    cur_valid_nxt  = cur_valid_r;
    last_frame_nxt = last_frame_r;
    last_valid_nxt = last_valid_r;
    origin_nxt     = origin_r;
    pass_nxt       = pass_r;
    dir_nxt        = dir_r;
    run_nxt        = run_r;
    if (commit) begin
      unique case (s1_cmd_r)
        CMD_START: begin
          run_nxt       = 1'b1;
          origin_nxt    = s1_frame_r;
          cur_frame_nxt = s1_frame_r;
          cur_valid_nxt = 1'b1;
          pass_nxt      = 16'd0;
          dir_nxt       = start_forward_r;
        end
        CMD_ADVANCE: begin
          last_frame_nxt = cur_frame_r;
          last_valid_nxt = cur_valid_r;
          if (cur_valid_r) begin
            pass_nxt = adv_now.pass;
            dir_nxt  = adv_now.dir;
            if (adv_now.valid) begin
              cur_frame_nxt = adv_now.frame;
            end else begin
              // sequence ended: drop to blank and stop
              cur_frame_nxt = 8'd0;
              cur_valid_nxt = 1'b0;
              run_nxt       = 1'b0;
            end
          end else begin
            // blank stays blank
            cur_frame_nxt = 8'd0;
            run_nxt       = 1'b0;
          end
        end
        CMD_BACK: begin
          // swap current and previous frames
          cur_frame_nxt  = last_frame_r;
          last_frame_nxt = cur_frame_r;
          cur_valid_nxt  = last_valid_r;
          last_valid_nxt = cur_valid_r;
        end
        default: ;  // unused code: hold state, still report it
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_frame_r  <= 8'd0;
      cur_valid_r  <= 1'b0;
      last_frame_r <= 8'd0;
      last_valid_r <= 1'b0;
      origin_r     <= 8'd0;
      pass_r       <= 16'd0;
      dir_r        <= 1'b1;
      run_r        <= 1'b0;
    end else begin
      cur_frame_r  <= cur_frame_nxt;
      cur_valid_r  <= cur_valid_nxt;
      last_frame_r <= last_frame_nxt;
      last_valid_r <= last_valid_nxt;
      origin_r     <= origin_nxt;
      pass_r       <= pass_nxt;
      dir_r        <= dir_nxt;
      run_r        <= run_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  // Lookahead: exactly what the next advance would give from the new state
  assign adv_look = step_frame(cur_frame_nxt, pass_nxt, dir_nxt, last_idx, playback_mode_r,
                               origin_nxt, max_loops_r);

  logic       look_ok;
  logic       cur_show;
  logic       prev_show;
  assign look_ok   = cur_valid_nxt && adv_look.valid && run_nxt;
  assign cur_show  = cur_valid_nxt && run_nxt;
  assign prev_show = last_valid_nxt && run_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  logic [7:0] res_frame_r, res_prev_r, res_look_r;
  logic       res_frame_shown_r, res_prev_shown_r, res_look_shown_r;
  logic       res_fwd_r, res_finished_r, res_running_r;

  always_ff @(posedge clk) begin
    if (commit) begin
      res_frame_r       <= cur_show ? cur_frame_nxt : 8'd0;
      res_frame_shown_r <= cur_show;
      res_prev_r        <= prev_show ? last_frame_nxt : 8'd0;
      res_prev_shown_r  <= prev_show;
      res_look_r        <= look_ok ? adv_look.frame : 8'd0;
      res_look_shown_r  <= look_ok;
      res_fwd_r         <= dir_nxt;
      res_finished_r    <= ~cur_valid_nxt;
      res_running_r     <= run_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_index     = res_frame_r;
  assign out_frame_shown     = res_frame_shown_r;
  assign out_prev_index      = res_prev_r;
  assign out_prev_shown      = res_prev_shown_r;
  assign out_lookahead_index = res_look_r;
  assign out_lookahead_shown = res_look_shown_r;
  assign out_going_forward   = res_fwd_r;
  assign out_finished        = res_finished_r;
  assign out_is_running      = res_running_r;

`ifndef ASSERT_OFF
  // A shown current frame is never reported as finished
  a_shown_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_shown |-> !out_finished)
    else $error("shown frame reported as finished");

  // Lookahead only shows on top of a shown current frame
  a_look_needs_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lookahead_shown |-> out_frame_shown)
    else $error("lookahead shown without current frame");

  // Previous frame only shows while running
  a_prev_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prev_shown |-> out_is_running)
    else $error("previous frame shown while idle");

  // A committed start loads its frame and sets running
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (s1_cmd_r == CMD_START) |=>
      run_r && cur_valid_r && (cur_frame_r == $past(s1_frame_r)))
    else $error("start did not load the sequencer state");
`endif

endmodule

>>> verif/tb_animation_frame_sequencer.sv
// Self-checking testbench for the animation frame sequencer: directed mode tests, then random traffic.
`timescale 1ns / 100ps

module tb_animation_frame_sequencer import afs_pkg::*;;

  // Command code outside the defined set; the block must leave its state alone
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Cycles from request to result plus slack, used before config writes and at the end
  localparam int unsigned SETTLE_CYCLES = 4;
  // Random requests to send, unused commands included
  localparam int unsigned RANDOM_REQUESTS = 1300;

  typedef struct packed {
    logic [7:0] frame_index;
    logic       frame_shown;
    logic [7:0] prev_index;
    logic       prev_shown;
    logic [7:0] lookahead_index;
    logic       lookahead_shown;
    logic       going_forward;
    logic       finished;
    logic       is_running;
  } frame_report_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_START;
  logic [7:0]  in_start_frame = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_frame_index;
  logic        out_frame_shown;
  logic [7:0]  out_prev_index;
  logic        out_prev_shown;
  logic [7:0]  out_lookahead_index;
  logic        out_lookahead_shown;
  logic        out_going_forward;
  logic        out_finished;
  logic        out_is_running;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_FRAME_COUNT;
  logic [15:0] cfg_data = 16'd0;

  animation_frame_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_start_frame      (in_start_frame),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_index     (out_frame_index),
    .out_frame_shown     (out_frame_shown),
    .out_prev_index      (out_prev_index),
    .out_prev_shown      (out_prev_shown),
    .out_lookahead_index (out_lookahead_index),
    .out_lookahead_shown (out_lookahead_shown),
    .out_going_forward   (out_going_forward),
    .out_finished        (out_finished),
    .out_is_running      (out_is_running),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Shadow copy of the programmed registers
  logic [8:0]  set_frame_count = 9'd256;
  mode_t       set_mode        = MODE_LOOP;
  logic [15:0] set_max_loops   = 16'd0;
  logic        set_start_fwd   = 1'b1;

  // Shadow copy of the sequencer state, at its reset values
  logic [7:0]  seq_cur     = 8'd0;
  logic        seq_cur_ok  = 1'b0;
  logic [7:0]  seq_prev    = 8'd0;
  logic        seq_prev_ok = 1'b0;
  logic [7:0]  seq_origin  = 8'd0;
  logic [15:0] seq_passes  = 16'd0;
  logic        seq_fwd     = 1'b1;
  logic        seq_running = 1'b0;

  // Results predicted for accepted requests, oldest first
  frame_report_t frame_reports[$];
  frame_report_t want;

  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned tx_quiet        = 0;
  int unsigned rx_hold         = 0;
  int unsigned rx_roll;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Kill a hung run; the slowest legal run is far below this
  initial begin
    #8_000_000;
    $display("tb_animation_frame_sequencer: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame step prediction
  // ---------------------------------------------------------------------------

  // Highest usable index: zero frames acts as one, large counts are capped
  function automatic logic [7:0] last_usable_frame();
    int unsigned n;
    n = 32'(set_frame_count);
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    if (n > 256) n = 256;
    return 8'(n - 1);
  endfunction

  // Wrap at an end: forward goes to 0 (or to 1 from 0), backward from 0 to the end
  function automatic logic [7:0] wrap_frame(logic [7:0] c, logic fwd, logic [7:0] last);
    if (fwd) return (c != 8'd0) ? 8'd0 : ((last > 8'd0) ? 8'd1 : 8'd0);
    return (c == 8'd0) ? last : c - 8'd1;
  endfunction

  // One advance from state s; valid drops when the sequence ends with a blank frame
  function automatic adv_t step_frame(adv_t s);
    adv_t       r;
    logic [7:0] last;
    r = s;
    r.valid = 1'b1;
    last = last_usable_frame();
    // Interior frames just move one step in the current direction
    if (s.frame > 8'd0 && s.frame < last) begin
      r.frame = s.dir ? s.frame + 8'd1 : s.frame - 8'd1;
      return r;
    end
    case (set_mode)
      MODE_LOOP: begin
        if (s.frame == seq_origin && r.pass != PASS_SAT) r.pass = r.pass + 16'd1;
        r.frame = wrap_frame(s.frame, s.dir, last);
      end
      MODE_ONCE: begin
        // Only the end where playback began may wrap; any other end blanks
        if (s.frame != seq_origin) r.valid = 1'b0;
        else r.frame = wrap_frame(s.frame, s.dir, last);
      end
      MODE_BOUNCE: begin
        if (r.pass != PASS_SAT) r.pass = r.pass + 16'd1;
        // Keep the direction on the first pass, reverse on every later one
        if (r.pass != 16'd1) r.dir = ~r.dir;
        if (r.dir) begin
          if (s.frame < last) r.frame = s.frame + 8'd1;
          else begin
            r.dir = 1'b0;
            r.frame = (last > 8'd0) ? last - 8'd1 : 8'd0;
          end
        end else begin
          if (s.frame > 8'd0) r.frame = s.frame - 8'd1;
          else begin
            r.dir = 1'b1;
            r.frame = (last > 8'd0) ? 8'd1 : 8'd0;
          end
        end
      end
      default: begin
        if (s.frame == seq_origin && r.pass != PASS_SAT) r.pass = r.pass + 16'd1;
        if (r.pass >= set_max_loops) r.valid = 1'b0;
        else r.frame = wrap_frame(s.frame, s.dir, last);
      end
    endcase
    return r;
  endfunction

  // Apply one accepted request to the shadow state and build its result
  function automatic frame_report_t sequence_step(logic [1:0] cmd, logic [7:0] sf);
    frame_report_t rep;
    adv_t          s;
    logic [7:0]    t_frame;
    logic          t_ok;
    logic          look_ok;
    case (cmd)
      CMD_START: begin
        seq_running = 1'b1;
        seq_origin  = sf;
        seq_cur     = sf;
        seq_cur_ok  = 1'b1;
        seq_passes  = 16'd0;
        seq_fwd     = set_start_fwd;
      end
      CMD_ADVANCE: begin
        seq_prev    = seq_cur;
        seq_prev_ok = seq_cur_ok;
        if (seq_cur_ok) begin
          s = '{frame: seq_cur, pass: seq_passes, dir: seq_fwd, valid: 1'b1};
          s = step_frame(s);
          seq_passes = s.pass;
          seq_fwd    = s.dir;
          if (s.valid) seq_cur = s.frame;
          else begin
            seq_cur     = 8'd0;
            seq_cur_ok  = 1'b0;
            seq_running = 1'b0;
          end
        end else begin
          // A blank frame stays blank
          seq_cur     = 8'd0;
          seq_running = 1'b0;
        end
      end
      CMD_BACK: begin
        t_frame     = seq_cur;
        seq_cur     = seq_prev;
        seq_prev    = t_frame;
        t_ok        = seq_cur_ok;
        seq_cur_ok  = seq_prev_ok;
        seq_prev_ok = t_ok;
      end
      default: ;
    endcase

    // Lookahead: what the next advance would give, without committing it
    s = '{frame: seq_cur, pass: seq_passes, dir: seq_fwd, valid: 1'b0};
    if (seq_cur_ok) s = step_frame(s);
    look_ok = s.valid & seq_running;

    rep.frame_shown     = seq_cur_ok & seq_running;
    rep.frame_index     = rep.frame_shown ? seq_cur : 8'd0;
    rep.prev_shown      = seq_prev_ok & seq_running;
    rep.prev_index      = rep.prev_shown ? seq_prev : 8'd0;
    rep.lookahead_shown = look_ok;
    rep.lookahead_index = look_ok ? s.frame : 8'd0;
    rep.going_forward   = seq_fwd;
    rep.finished        = ~seq_cur_ok;
    rep.is_running      = seq_running;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("result %0d %s: got %0d, predicted %0d",
                                results_checked, name, got, exp_val));
  endtask

  // Compare every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frame_reports.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = frame_reports.pop_front();
        check_field("frame_index",     32'(out_frame_index),     32'(want.frame_index));
        check_field("frame_shown",     32'(out_frame_shown),     32'(want.frame_shown));
        check_field("prev_index",      32'(out_prev_index),      32'(want.prev_index));
        check_field("prev_shown",      32'(out_prev_shown),      32'(want.prev_shown));
        check_field("lookahead_index", 32'(out_lookahead_index),
                    32'(want.lookahead_index));
        check_field("lookahead_shown", 32'(out_lookahead_shown),
                    32'(want.lookahead_shown));
        check_field("going_forward",   32'(out_going_forward),   32'(want.going_forward));
        check_field("finished",        32'(out_finished),        32'(want.finished));
        check_field("is_running",      32'(out_is_running),      32'(want.is_running));
      end
      results_checked++;
    end
  end

  // Result-side backpressure: hold each stall/no-stall choice for a random run.
  // Most runs are short, a few stalls are long, and now and then a long quiet stretch.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 55) begin
        out_stall <= 1'b0;
        rx_hold   <= $urandom_range(0, 5);
      end else if (rx_roll < 85) begin
        out_stall <= 1'b1;
        rx_hold   <= $urandom_range(0, 2);
      end else if (rx_roll < 95) begin
        out_stall <= 1'b1;
        rx_hold   <= $urandom_range(3, 11);
      end else if (rx_roll < 97) begin
        out_stall <= 1'b1;
        rx_hold   <= $urandom_range(20, 60);
      end else begin
        out_stall <= 1'b0;
        rx_hold   <= $urandom_range(50, 200);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request and configuration drivers
  // ---------------------------------------------------------------------------

  // Idle cycles ahead of the next request: mostly none or short, a few long,
  // and occasional runs of back-to-back requests
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (tx_quiet != 0) begin
      tx_quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      tx_quiet = $urandom_range(30, 100);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Send one request; valid stays high afterwards so the next one can follow
  // back to back, and settle() drops it
  task automatic send_request(logic [1:0] cmd, logic [7:0] sf);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_start_frame <= sf;
    do @(posedge clk); while (in_stall);
    frame_reports.insert(frame_reports.size(), sequence_step(cmd, sf));
  endtask

  // Drop valid, drain every outstanding result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (frame_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_COUNT:   set_frame_count = value[8:0];
      REG_PLAYBACK_MODE: set_mode        = mode_t'(value[1:0]);
      REG_MAX_LOOPS:     set_max_loops   = value;
      REG_START_FORWARD: set_start_fwd   = value[0];
      default: ;
    endcase
  endtask

  // Program all four registers; call only while the block is idle
  task automatic configure(logic [8:0] fc, mode_t mode, logic [15:0] loops, logic fwd);
    write_reg(REG_FRAME_COUNT, {7'd0, fc});
    write_reg(REG_PLAYBACK_MODE, {14'd0, mode});
    write_reg(REG_MAX_LOOPS, loops);
    write_reg(REG_START_FORWARD, {15'd0, fwd});
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: advance and back on the blank reset state, the unused
  // command, then a start at the top index wrapping forward in loop mode
  task automatic test_after_reset();
    send_request(CMD_ADVANCE, 8'd0);
    send_request(CMD_UNUSED, 8'd255);
    send_request(CMD_BACK, 8'd0);
    send_request(CMD_START, 8'd255);
    send_request(CMD_ADVANCE, 8'd0);
    send_request(CMD_ADVANCE, 8'd0);
    send_request(CMD_BACK, 8'd0);
    settle();
  endtask

  // Once mode: single frame stepping in place, a start beyond the last frame that
  // stops after stepping down once, and a blank frame that stays blank
  task automatic test_once_mode();
    configure(9'd1, MODE_ONCE, 16'd0, 1'b0);
    send_request(CMD_START, 8'd0);
    send_request(CMD_ADVANCE, 8'd0);
    settle();
    configure(9'd4, MODE_ONCE, 16'd0, 1'b0);
    send_request(CMD_START, 8'd200);
    repeat (3) send_request(CMD_ADVANCE, 8'd0);
    settle();
  endtask

  // Bounce mode: zero frame count acting as one, then reversals at both ends
  task automatic test_bounce_mode();
    configure(9'd0, MODE_BOUNCE, 16'd0, 1'b1);
    send_request(CMD_START, 8'd0);
    send_request(CMD_ADVANCE, 8'd0);
    settle();
    configure(9'd3, MODE_BOUNCE, 16'd0, 1'b1);
    send_request(CMD_START, 8'd1);
    repeat (4) send_request(CMD_ADVANCE, 8'd0);
    settle();
  endtask

  // Loop-N mode: capped frame count with a single pass, then the largest pass limit
  task automatic test_loop_n_mode();
    configure(9'd511, MODE_LOOP_N, 16'd1, 1'b0);
    send_request(CMD_START, 8'd0);
    repeat (2) send_request(CMD_ADVANCE, 8'd0);
    settle();
    configure(9'd2, MODE_LOOP_N, 16'hFFFF, 1'b1);
    send_request(CMD_START, 8'd1);
    repeat (2) send_request(CMD_ADVANCE, 8'd0);
    settle();
  endtask

  // Random phases: a random setting (small frame counts favored so the ends
  // are reached often), then mostly start-then-advance playback with some back,
  // restart and unused commands mixed in
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned roll;
    logic [8:0]  fc;
    logic [15:0] loops;
    logic [7:0]  last;
    logic [7:0]  sf;
    logic [1:0]  cmd;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) fc = 9'($urandom_range(1, 8));
      else if (roll < 80) fc = 9'($urandom_range(9, 40));
      else if (roll < 90) begin
        case ($urandom_range(0, 3))
          0: fc = 9'd0;
          1: fc = 9'd1;
          2: fc = 9'd256;
          default: fc = 9'd511;
        endcase
      end else fc = 9'($urandom_range(0, 511));
      roll = $urandom_range(0, 99);
      if (roll < 70) loops = 16'($urandom_range(0, 4));
      else if (roll < 85) loops = 16'($urandom_range(5, 20));
      else if (roll < 95) loops = 16'hFFFF;
      else loops = 16'($urandom_range(0, 65535));
      configure(fc, mode_t'(2'($urandom_range(0, 3))), loops, 1'($urandom_range(0, 1)));
      last = last_usable_frame();

      phase_len = $urandom_range(10, 60);
      for (int unsigned i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        // Open most phases with a start; restart half the time once blank
        if ((i == 0 && roll < 90) || (!seq_cur_ok && roll < 50)) cmd = CMD_START;
        else begin
          roll = $urandom_range(0, 99);
          if (roll < 72) cmd = CMD_ADVANCE;
          else if (roll < 84) cmd = CMD_BACK;
          else if (roll < 95) cmd = CMD_START;
          else cmd = CMD_UNUSED;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) sf = 8'($urandom_range(0, 32'(last)));
        else if (roll < 75) sf = last;
        else if (roll < 85) sf = 8'd0;
        else sf = 8'($urandom_range(0, 255));
        send_request(cmd, sf);
        sent++;
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_once_mode();
    test_bounce_mode();
    test_loop_n_mode();
    test_random_traffic();

    // settle() already drained; give a stray late result time to show up
    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0 && frame_reports.size() == 0) begin
      $display("tb_animation_frame_sequencer: clean");
    end else begin
      $display("tb_animation_frame_sequencer: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/afs_pkg.sv
hdl/animation_frame_sequencer.sv
verif/tb_animation_frame_sequencer.sv
